### rtl/thsr_pkg.sv
// Package: types and constants of the thermostat and charge relay controller.
`default_nettype none

package thsr_pkg;

   // Channel counts: boiler plus three charge triggers
   localparam int TRIGGER_COUNT = 3;
   localparam int CHAN_COUNT    = 1 + TRIGGER_COUNT;

   // Minimum dwell between ordinary level changes, in ticks
   localparam logic [7:0] DWELL_TICKS_MIN = 8'd60;
   localparam logic [7:0] ELAPSED_MAX     = 8'd255;

   // Plausible temperature range in tenths of a degree
   localparam logic signed [12:0] TEMP_LOW_LIMIT  = -13'sd400;
   localparam logic signed [12:0] TEMP_HIGH_LIMIT = 13'sd1250;

   // Configuration port widths and register indexes
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_ON_BELOW  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OFF_AT    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TRIG1_LOW = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TRIG1_HI  = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TRIG2_LOW = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TRIG2_HI  = 8'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TRIG3_LOW = 8'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_TRIG3_HI  = 8'd7;

   // Register reset values
   localparam logic [7:0] THRESH_RESET   = 8'hD8; // -40
   localparam logic [6:0] WIN_LOW_RESET  = 7'd100;
   localparam logic [6:0] WIN_HIGH_RESET = 7'd0;

   // Input word: one control tick
   typedef struct packed {
      logic signed [11:0] temp_tenths;
      logic               temp_valid;
      logic [6:0]         charge_pct;
      logic               charge_valid;
   } req_type;

   // Result word: applied levels, remaining waits and fault flags
   typedef struct packed {
      logic [3:0] outputs_on;
      logic [7:0] boiler_wait_s;
      logic [7:0] trig1_wait_s;
      logic [7:0] trig2_wait_s;
      logic [7:0] trig3_wait_s;
      logic       temp_fault;
      logic       charge_fault;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/thermostat_and_soc_relay_controller_unit.sv
// Thermostat with hysteresis and three charge-window triggers, minimum dwell per output.
// A word accepted into the input register passes through one pass of compares and four
//   8-bit dwell counters into the result register, which drives rsp_valid and rsp_data.
//   Throughput: one word per cycle while rsp_ready keeps the result register draining.
// Reset (synchronous, active high): all outputs off, dwell counters zero, thresholds -40,
//   every window low bound 100 and high bound 0; both pipeline stages empty.
`default_nettype none

module thermostat_and_soc_relay_controller_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire thsr_pkg::req_type                  req_data,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      thsr_pkg::rsp_type                  rsp_data,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [thsr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [thsr_pkg::CSR_DATA_W-1:0]    csr_data
);

   // Configuration registers
   logic [7:0] on_below_ff;
   logic [7:0] off_at_ff;
   logic [6:0] win_low_ff  [thsr_pkg::TRIGGER_COUNT];
   logic [6:0] win_high_ff [thsr_pkg::TRIGGER_COUNT];

   // Controller state
   logic       demand_ff;
   logic       demand_in;
   logic [thsr_pkg::CHAN_COUNT-1:0] applied_ff;
   logic [thsr_pkg::CHAN_COUNT-1:0] applied_in;
   logic [7:0] elapsed_ff [thsr_pkg::CHAN_COUNT];
   logic [7:0] elapsed_in [thsr_pkg::CHAN_COUNT];

   // Pipeline registers
   logic              stg_valid_ff;
   thsr_pkg::req_type stg_data_ff;
   logic              rsp_valid_ff;
   thsr_pkg::rsp_type rsp_data_ff;
   thsr_pkg::rsp_type rsp_in;

   // Handshake
   logic out_free;
   logic advance;

   // Datapath temporaries
   logic signed [12:0] temp_ext;
   logic signed [12:0] on_below_ext;
   logic signed [12:0] off_at_ext;
   logic signed [12:0] lo_tenths;
   logic signed [12:0] hi_tenths;
   logic               temp_fault;
   logic               overheat;
   logic               charge_fault;
   logic [thsr_pkg::CHAN_COUNT-1:0] want;
   logic [thsr_pkg::CHAN_COUNT-1:0] off_now;
   logic [thsr_pkg::CHAN_COUNT-1:0] apply_now;
   logic [7:0] since      [thsr_pkg::CHAN_COUNT];
   logic [7:0] wait_ticks [thsr_pkg::CHAN_COUNT];

   // Stage moves into the result register when that register is empty or being drained
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = stg_valid_ff && out_free;
   assign req_ready = !stg_valid_ff || out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         on_below_ff <= thsr_pkg::THRESH_RESET;
         off_at_ff   <= thsr_pkg::THRESH_RESET;
         for (int i = 0; i < thsr_pkg::TRIGGER_COUNT; i++) begin
            win_low_ff[i]  <= thsr_pkg::WIN_LOW_RESET;
            win_high_ff[i] <= thsr_pkg::WIN_HIGH_RESET;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            thsr_pkg::REG_ON_BELOW:  on_below_ff    <= csr_data;
            thsr_pkg::REG_OFF_AT:    off_at_ff      <= csr_data;
            thsr_pkg::REG_TRIG1_LOW: win_low_ff[0]  <= csr_data[6:0];
            thsr_pkg::REG_TRIG1_HI:  win_high_ff[0] <= csr_data[6:0];
            thsr_pkg::REG_TRIG2_LOW: win_low_ff[1]  <= csr_data[6:0];
            thsr_pkg::REG_TRIG2_HI:  win_high_ff[1] <= csr_data[6:0];
            thsr_pkg::REG_TRIG3_LOW: win_low_ff[2]  <= csr_data[6:0];
            thsr_pkg::REG_TRIG3_HI:  win_high_ff[2] <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // Boiler demand with hysteresis; thresholds scaled to tenths as 8x + 2x
   always_comb begin
      temp_ext     = {stg_data_ff.temp_tenths[11], stg_data_ff.temp_tenths};
      on_below_ext = {{5{on_below_ff[7]}}, on_below_ff};
      off_at_ext   = {{5{off_at_ff[7]}}, off_at_ff};
      lo_tenths    = (on_below_ext <<< 3) + (on_below_ext <<< 1);
      hi_tenths    = (off_at_ext <<< 3) + (off_at_ext <<< 1);
      temp_fault   = !stg_data_ff.temp_valid
                     || (temp_ext < thsr_pkg::TEMP_LOW_LIMIT)
                     || (temp_ext > thsr_pkg::TEMP_HIGH_LIMIT);
      overheat     = temp_ext >= hi_tenths;
      if (temp_fault) begin
         demand_in = 1'b0;
      end else if (overheat) begin
         demand_in = 1'b0;
      end else if (temp_ext < lo_tenths) begin
         demand_in = 1'b1;
      end else begin
         demand_in = demand_ff;
      end
      want[0]    = demand_in;
      off_now[0] = temp_fault || overheat;

      // Charge windows; a missing charge forces every trigger off at once
      charge_fault = !stg_data_ff.charge_valid;
      for (int i = 0; i < thsr_pkg::TRIGGER_COUNT; i++) begin
         want[1+i]    = stg_data_ff.charge_valid
                        && (stg_data_ff.charge_pct >= win_low_ff[i])
                        && (stg_data_ff.charge_pct <= win_high_ff[i]);
         off_now[1+i] = charge_fault;
      end
   end

   // Per-channel dwell: apply after the dwell, or at once for a safety switch-off
   always_comb begin
      for (int i = 0; i < thsr_pkg::CHAN_COUNT; i++) begin
         apply_now[i] = (want[i] != applied_ff[i])
                        && ((elapsed_ff[i] >= thsr_pkg::DWELL_TICKS_MIN)
                            || (!want[i] && off_now[i]));
         applied_in[i] = apply_now[i] ? want[i] : applied_ff[i];
         since[i]      = apply_now[i] ? 8'd0 : elapsed_ff[i];
         if (want[i] == applied_in[i]) begin
            wait_ticks[i] = 8'd0;
         end else if (since[i] >= thsr_pkg::DWELL_TICKS_MIN) begin
            wait_ticks[i] = 8'd1;
         end else begin
            wait_ticks[i] = thsr_pkg::DWELL_TICKS_MIN - since[i];
         end
         elapsed_in[i] = (since[i] == thsr_pkg::ELAPSED_MAX) ? thsr_pkg::ELAPSED_MAX
                                                              : since[i] + 8'd1;
      end
   end

   // Result word assembly
   always_comb begin
      rsp_in.outputs_on    = applied_in;
      rsp_in.boiler_wait_s = wait_ticks[0];
      rsp_in.trig1_wait_s  = wait_ticks[1];
      rsp_in.trig2_wait_s  = wait_ticks[2];
      rsp_in.trig3_wait_s  = wait_ticks[3];
      rsp_in.temp_fault    = temp_fault;
      rsp_in.charge_fault  = charge_fault;
   end

   // Control state and valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         demand_ff    <= 1'b0;
         applied_ff   <= '0;
         for (int i = 0; i < thsr_pkg::CHAN_COUNT; i++) begin
            elapsed_ff[i] <= 8'd0;
         end
      end else begin
         if (req_ready) begin
            stg_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= stg_valid_ff;
         end
         if (advance) begin
            demand_ff  <= demand_in;
            applied_ff <= applied_in;
            for (int i = 0; i < thsr_pkg::CHAN_COUNT; i++) begin
               elapsed_ff[i] <= elapsed_in[i];
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stg_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // A shown word always matches the applied levels held in state
   a_levels_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.outputs_on == applied_ff))
      else $error("reported levels differ from applied state");

   // Temperature fault switches the boiler off in the same word
   a_temp_fault_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.temp_fault) |->
         (!rsp_data_ff.outputs_on[0] && (rsp_data_ff.boiler_wait_s == 8'd0)))
      else $error("boiler not off on temperature fault");

   // Charge fault switches every trigger off with nothing pending
   a_charge_fault_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.charge_fault) |->
         ((rsp_data_ff.outputs_on[3:1] == 3'b000)
          && (rsp_data_ff.trig1_wait_s == 8'd0)
          && (rsp_data_ff.trig2_wait_s == 8'd0)
          && (rsp_data_ff.trig3_wait_s == 8'd0)))
      else $error("triggers not off on charge fault");

   // A pending wait never exceeds the dwell
   a_wait_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.boiler_wait_s <= thsr_pkg::DWELL_TICKS_MIN)
                        && (rsp_data_ff.trig1_wait_s <= thsr_pkg::DWELL_TICKS_MIN)
                        && (rsp_data_ff.trig2_wait_s <= thsr_pkg::DWELL_TICKS_MIN)
                        && (rsp_data_ff.trig3_wait_s <= thsr_pkg::DWELL_TICKS_MIN)))
      else $error("wait exceeds dwell");

   // State moves only when a word moves into the result register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (!advance && !$past(reset)) |=> $stable(applied_ff))
      else $error("applied state changed without a word");

endmodule

`default_nettype wire
